/* sv/rpq_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the RAID-6 P/Q column engine.
// Field polynomial 0x11d; no dependencies.
package rpq_pkg;

    localparam int DEF_MAX_DATA_DISKS = 8;
    localparam int BYTE_W             = 8;
    localparam int CFG_DATA_W         = 4;
    localparam int CFG_INDEX_W        = 2;

    localparam logic [2:0] MODE_GEN    = 3'd0;
    localparam logic [2:0] MODE_REB_P  = 3'd1;
    localparam logic [2:0] MODE_REB_Q  = 3'd2;
    localparam logic [2:0] MODE_DUAL   = 3'd3;
    localparam logic [2:0] MODE_VERIFY = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISKS_IN_USE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILED_FIRST  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILED_SECOND = 2'd3;

    localparam logic [2:0] RST_MODE          = MODE_GEN;
    localparam logic [3:0] RST_DISKS_IN_USE  = 4'd8;
    localparam logic [2:0] RST_FAILED_FIRST  = 3'd0;
    localparam logic [2:0] RST_FAILED_SECOND = 3'd1;

    localparam logic [7:0] GF_POLY_LOW = 8'h1d;

    // 2^i and 2^-i for i = 0..7
    localparam logic [7:0][7:0] POW2 =
        {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01};
    localparam logic [7:0][7:0] INV_POW2 =
        {8'h1b, 8'h36, 8'h6c, 8'hd8, 8'had, 8'h47, 8'h8e, 8'h01};

    typedef struct packed {
        logic [63:0] column_data;
        logic [7:0]  parity_p_in;
        logic [7:0]  parity_q_in;
    } t_in;

    typedef struct packed {
        logic [7:0] parity_p_out;
        logic [7:0] parity_q_out;
        logic [7:0] rebuilt_first;
        logic [7:0] rebuilt_second;
        logic [1:0] check_status;
    } t_out;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] n_eff;
        logic [2:0] failed_first;
        logic [2:0] failed_second;
    } t_cfg;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                r = r ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r    = 8'h01;
        base = v;
        e    = 8'hfe;
        for (int k = 0; k < 8; k++) begin
            if (e[k]) begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    // inverse of 2^f1 ^ 2^f2, indexed by {f1, f2}
    function automatic logic [63:0][7:0] build_dual_inv();
        logic [63:0][7:0] t;
        logic [5:0]       idx;
        t = '0;
        for (int i = 0; i < 64; i++) begin
            idx  = 6'(i);
            t[i] = gf_inv(POW2[idx[5:3]] ^ POW2[idx[2:0]]);
        end
        return t;
    endfunction

    localparam logic [63:0][7:0] DUAL_INV = build_dual_inv();

endpackage

/* sv/raid6_pq_column_engine.sv */
// RAID-6 P/Q column engine over GF(2^8): lanes, merge and two solver stages.
// Throughput: one column per cycle unless i_ready stalls the output.
// Each stage holds one item and advances when the stage after it is empty or moving,
// so input is taken while a result waits, as long as some stage is still empty.
// Reset: synchronous active-low; clears stage valids and loads register defaults.
// Depends on rpq_pkg, rpq_lane, rpq_merge, rpq_solve.
module raid6_pq_column_engine
    import rpq_pkg::*;
#(
    parameter int MAX_DATA_DISKS = DEF_MAX_DATA_DISKS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_in                    i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_out                   o_data
);

    localparam logic [3:0] MAX_DISKS_W = 4'(MAX_DATA_DISKS);

    logic [2:0] r_mode;
    logic [3:0] r_disks;
    logic [2:0] r_fail1;
    logic [2:0] r_fail2;
    t_cfg       cfg;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    logic [7:0] r_pin1;
    logic [7:0] r_qin1;
    logic [MAX_DATA_DISKS-1:0][7:0] lane_p;
    logic [MAX_DATA_DISKS-1:0][7:0] lane_q;
    logic [7:0] pf;
    logic [7:0] qf;
    logic [7:0] pin2;
    logic [7:0] qin2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_disks <= RST_DISKS_IN_USE;
            r_fail1 <= RST_FAILED_FIRST;
            r_fail2 <= RST_FAILED_SECOND;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE:          r_mode  <= i_cfg_data[2:0];
                CFG_DISKS_IN_USE:  r_disks <= i_cfg_data;
                CFG_FAILED_FIRST:  r_fail1 <= i_cfg_data[2:0];
                CFG_FAILED_SECOND: r_fail2 <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.mode          = r_mode;
        cfg.n_eff         = (r_disks > MAX_DISKS_W) ? MAX_DISKS_W : r_disks;
        cfg.failed_first  = r_fail1;
        cfg.failed_second = r_fail2;
    end

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pin1 <= i_data.parity_p_in;
            r_qin1 <= i_data.parity_q_in;
        end
    end

    for (genvar g = 0; g < MAX_DATA_DISKS; g++) begin : g_lane
        rpq_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (rdy1),
            .i_cfg  (cfg),
            .i_byte (i_data.column_data[BYTE_W*g +: BYTE_W]),
            .o_p    (lane_p[g]),
            .o_q    (lane_q[g])
        );
    end

    rpq_merge #(
        .N_LANES (MAX_DATA_DISKS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (rdy2),
        .i_lane_p (lane_p),
        .i_lane_q (lane_q),
        .i_pin    (r_pin1),
        .i_qin    (r_qin1),
        .o_pf     (pf),
        .o_qf     (qf),
        .o_pin    (pin2),
        .o_qin    (qin2)
    );

    rpq_solve u_solve (
        .i_clk    (i_clk),
        .i_en_a   (rdy3),
        .i_en_b   (rdy4),
        .i_cfg    (cfg),
        .i_pf     (pf),
        .i_qf     (qf),
        .i_pin    (pin2),
        .i_qin    (qin2),
        .o_result (o_data)
    );

endmodule

/* sv/rpq_lane.sv */
// One data-disk lane: masks the disk byte and scales it by its Q coefficient.
// Depends on rpq_pkg.
module rpq_lane
    import rpq_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_byte,
    output logic [7:0] o_p,
    output logic [7:0] o_q
);

    localparam logic [2:0] LANE_ID = 3'(LANE);

    logic       skip;
    logic       use_byte;
    logic [7:0] d;
    logic [7:0] r_p;
    logic [7:0] r_q;

    always_comb begin
        skip = (((i_cfg.mode == MODE_REB_P) || (i_cfg.mode == MODE_REB_Q) ||
                 (i_cfg.mode == MODE_DUAL)) && (LANE_ID == i_cfg.failed_first)) ||
               ((i_cfg.mode == MODE_DUAL) && (LANE_ID == i_cfg.failed_second));
        use_byte = ({1'b0, LANE_ID} < i_cfg.n_eff) && !skip;
        d = use_byte ? i_byte : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= d;
            r_q <= gf_mul(d, POW2[LANE_ID]);
        end
    end

    assign o_p = r_p;
    assign o_q = r_q;

endmodule

/* sv/rpq_merge.sv */
// Merge stage: XOR-combines the lane contributions into P and Q sums.
// Depends on rpq_pkg.
module rpq_merge
    import rpq_pkg::*;
#(
    parameter int N_LANES = DEF_MAX_DATA_DISKS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [N_LANES-1:0][7:0] i_lane_p,
    input  logic [N_LANES-1:0][7:0] i_lane_q,
    input  logic [7:0]             i_pin,
    input  logic [7:0]             i_qin,
    output logic [7:0]             o_pf,
    output logic [7:0]             o_qf,
    output logic [7:0]             o_pin,
    output logic [7:0]             o_qin
);

    logic [7:0] n_pf;
    logic [7:0] n_qf;
    logic [7:0] r_pf;
    logic [7:0] r_qf;
    logic [7:0] r_pin;
    logic [7:0] r_qin;

    always_comb begin
        n_pf = 8'h00;
        n_qf = 8'h00;
        for (int i = 0; i < N_LANES; i++) begin
            n_pf = n_pf ^ i_lane_p[i];
            n_qf = n_qf ^ i_lane_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pf  <= n_pf;
            r_qf  <= n_qf;
            r_pin <= i_pin;
            r_qin <= i_qin;
        end
    end

    assign o_pf  = r_pf;
    assign o_qf  = r_qf;
    assign o_pin = r_pin;
    assign o_qin = r_qin;

endmodule

/* sv/rpq_solve.sv */
// Two-stage solver: syndrome scaling, then rebuild, parity update and check.
// Depends on rpq_pkg.
module rpq_solve
    import rpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en_a,
    input  logic       i_en_b,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_pf,
    input  logic [7:0] i_qf,
    input  logic [7:0] i_pin,
    input  logic [7:0] i_qin,
    output t_out       o_result
);

    logic [7:0] mul_x;
    logic [7:0] mul_y;
    logic [7:0] r_pf;
    logic [7:0] r_qf;
    logic [7:0] r_pin;
    logic [7:0] r_qin;
    logic [7:0] r_prod;
    logic [7:0] ps;
    logic [7:0] qs;
    logic       f1_in_use;
    t_out       n_res;
    t_out       r_res;

    always_comb begin
        case (i_cfg.mode)
            MODE_REB_P: begin
                mul_x = i_pf ^ i_pin;
                mul_y = POW2[i_cfg.failed_first];
            end
            MODE_REB_Q: begin
                mul_x = i_qf ^ i_qin;
                mul_y = INV_POW2[i_cfg.failed_first];
            end
            MODE_DUAL: begin
                mul_x = i_pf ^ i_pin;
                mul_y = POW2[i_cfg.failed_second];
            end
            default: begin
                mul_x = 8'h00;
                mul_y = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_pf   <= i_pf;
            r_qf   <= i_qf;
            r_pin  <= i_pin;
            r_qin  <= i_qin;
            r_prod <= gf_mul(mul_x, mul_y);
        end
    end

    always_comb begin
        ps        = r_pf ^ r_pin;
        qs        = r_qf ^ r_qin;
        f1_in_use = {1'b0, i_cfg.failed_first} < i_cfg.n_eff;
        n_res     = '0;
        case (i_cfg.mode)
            MODE_GEN: begin
                n_res.parity_p_out = r_pf;
                n_res.parity_q_out = r_qf;
            end
            MODE_REB_P: begin
                n_res.rebuilt_first = ps;
                n_res.parity_p_out  = r_pin;
                n_res.parity_q_out  = r_qf ^ (f1_in_use ? r_prod : 8'h00);
            end
            MODE_REB_Q: begin
                n_res.rebuilt_first = r_prod;
                n_res.parity_q_out  = r_qin;
                n_res.parity_p_out  = r_pf ^ (f1_in_use ? r_prod : 8'h00);
            end
            MODE_DUAL: begin
                n_res.parity_p_out = r_pin;
                n_res.parity_q_out = r_qin;
                if (i_cfg.failed_first != i_cfg.failed_second) begin
                    n_res.rebuilt_first  = gf_mul(qs ^ r_prod,
                        DUAL_INV[{i_cfg.failed_first, i_cfg.failed_second}]);
                    n_res.rebuilt_second = ps ^ n_res.rebuilt_first;
                end
            end
            MODE_VERIFY: begin
                n_res.parity_p_out = r_pf;
                n_res.parity_q_out = r_qf;
                n_res.check_status = {(r_qf != r_qin), (r_pf != r_pin)};
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for raid6_pq_column_engine: directed column table, then random phases.
// Predicts P, Q, rebuilt bytes and verify status with its own GF(2^8) arithmetic.
// Depends on rpq_pkg and the raid6_pq_column_engine RTL.
module testbench;
    import rpq_pkg::*;

    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_P_BAD = 2'd1;
    localparam logic [1:0] ST_Q_BAD = 2'd2;
    localparam logic [1:0] ST_BOTH  = 2'd3;

    localparam int NUM_PHASES   = 30;
    localparam int PHASE_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] disks;
        logic [2:0] f1;
        logic [2:0] f2;
    } col_cfg_t;

    typedef struct {
        col_cfg_t cfg;
        t_in      col;
        bit       pinned;
        t_out     want;
    } col_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    t_in                    i_data;
    logic                   o_valid;
    logic                   i_ready;
    t_out                   o_data;

    col_cfg_t cfg_now;
    t_out     pending_cols[$];
    col_row_t col_table[$];
    int       mismatches;
    bit       steady;

    raid6_pq_column_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc ^= sh;
            end
            sh = sh[7] ? ({sh[6:0], 1'b0} ^ 8'h1d) : {sh[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_exp2(input int e);
        logic [7:0] acc;
        acc = 8'h01;
        repeat (e) acc = gf_mult(acc, 8'h02);
        return acc;
    endfunction

    // x^254 is the inverse of x for nonzero x
    function automatic logic [7:0] gf_recip(input logic [7:0] x);
        logic [7:0] acc;
        acc = 8'h01;
        repeat (254) acc = gf_mult(acc, x);
        return acc;
    endfunction

    function automatic t_out predict_column(input col_cfg_t c, input t_in x);
        t_out       r;
        int         n;
        logic [7:0] d;
        logic [7:0] pf;
        logic [7:0] qf;
        logic [7:0] ps;
        logic [7:0] qs;
        logic [7:0] ca;
        logic [7:0] cb;
        r  = '0;
        pf = 8'h00;
        qf = 8'h00;
        n  = (c.disks > 4'd8) ? 8 : int'(c.disks);
        for (int i = 0; i < n; i++) begin
            d = x.column_data[8*i +: 8];
            if (!((c.mode == MODE_REB_P || c.mode == MODE_REB_Q || c.mode == MODE_DUAL)
                  && i == int'(c.f1)) && !(c.mode == MODE_DUAL && i == int'(c.f2))) begin
                pf ^= d;
                qf ^= gf_mult(gf_exp2(i), d);
            end
        end
        case (c.mode)
            MODE_GEN: begin
                r.parity_p_out = pf;
                r.parity_q_out = qf;
            end
            MODE_REB_P: begin
                r.rebuilt_first = pf ^ x.parity_p_in;
                r.parity_p_out  = x.parity_p_in;
                r.parity_q_out  = qf;
                if (int'(c.f1) < n) begin
                    r.parity_q_out ^= gf_mult(gf_exp2(int'(c.f1)), r.rebuilt_first);
                end
            end
            MODE_REB_Q: begin
                r.rebuilt_first = gf_mult(qf ^ x.parity_q_in, gf_exp2(255 - int'(c.f1)));
                r.parity_q_out  = x.parity_q_in;
                r.parity_p_out  = pf;
                if (int'(c.f1) < n) begin
                    r.parity_p_out ^= r.rebuilt_first;
                end
            end
            MODE_DUAL: begin
                ps = pf ^ x.parity_p_in;
                qs = qf ^ x.parity_q_in;
                ca = gf_exp2(int'(c.f1));
                cb = gf_exp2(int'(c.f2));
                r.parity_p_out = x.parity_p_in;
                r.parity_q_out = x.parity_q_in;
                if (c.f1 != c.f2) begin
                    r.rebuilt_first  = gf_mult(qs ^ gf_mult(cb, ps), gf_recip(ca ^ cb));
                    r.rebuilt_second = ps ^ r.rebuilt_first;
                end
            end
            MODE_VERIFY: begin
                r.parity_p_out = pf;
                r.parity_q_out = qf;
                r.check_status = {qf != x.parity_q_in, pf != x.parity_p_in};
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic t_in random_column(input col_cfg_t c);
        t_in      x;
        col_cfg_t gc;
        t_out     g;
        int       k;
        x.column_data = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            k = $urandom_range(15);
            if (k == 0) begin
                x.column_data[8*i +: 8] = 8'h00;
            end else if (k == 1) begin
                x.column_data[8*i +: 8] = 8'hff;
            end
        end
        x.parity_p_in = 8'($urandom);
        x.parity_q_in = 8'($urandom);
        k = $urandom_range(9);
        if (k >= 4) begin
            gc      = c;
            gc.mode = MODE_GEN;
            g       = predict_column(gc, x);
            x.parity_p_in = g.parity_p_out;
            x.parity_q_in = g.parity_q_out;
            if (k == 8) begin
                x.parity_p_in[$urandom_range(7)] ^= 1'b1;
            end else if (k == 9) begin
                x.parity_q_in[$urandom_range(7)] ^= 1'b1;
            end
        end
        return x;
    endfunction

    function automatic col_cfg_t random_cfg();
        col_cfg_t c;
        int       k;
        k      = $urandom_range(19);
        c.mode = (k < 18) ? 3'(k % 5) : 3'(5 + $urandom_range(2));
        c.disks = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        c.f1 = 3'($urandom_range(7));
        c.f2 = 3'($urandom_range(7));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input col_cfg_t c, input t_in x, input bit pinned, input t_out w);
        col_row_t rw;
        rw.cfg    = c;
        rw.col    = x;
        rw.pinned = pinned;
        rw.want   = w;
        col_table.push_back(rw);
    endtask

    task automatic apply_cfg(input col_cfg_t c);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= {1'b0, c.mode};
        @(posedge i_clk);
        cfg_now.mode = c.mode;
        i_cfg_index <= CFG_DISKS_IN_USE;
        i_cfg_data  <= c.disks;
        @(posedge i_clk);
        cfg_now.disks = c.disks;
        i_cfg_index <= CFG_FAILED_FIRST;
        i_cfg_data  <= {1'b0, c.f1};
        @(posedge i_clk);
        cfg_now.f1 = c.f1;
        i_cfg_index <= CFG_FAILED_SECOND;
        i_cfg_data  <= {1'b0, c.f2};
        @(posedge i_clk);
        cfg_now.f2 = c.f2;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_cols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_column(input t_in x, input bit pinned, input t_out w);
        while (!steady && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        do @(posedge i_clk); while (!o_ready);
        pending_cols.push_back(pinned ? w : predict_column(cfg_now, x));
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        i_ready <= steady || ($urandom_range(99) >= 9);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_cols.size() == 0) begin
                report_mismatch("unexpected result", o_data.parity_p_out, 8'h00);
            end else begin
                want = pending_cols.pop_front();
                if (o_data.parity_p_out !== want.parity_p_out)
                    report_mismatch("parity_p_out", o_data.parity_p_out, want.parity_p_out);
                if (o_data.parity_q_out !== want.parity_q_out)
                    report_mismatch("parity_q_out", o_data.parity_q_out, want.parity_q_out);
                if (o_data.rebuilt_first !== want.rebuilt_first)
                    report_mismatch("rebuilt_first", o_data.rebuilt_first, want.rebuilt_first);
                if (o_data.rebuilt_second !== want.rebuilt_second)
                    report_mismatch("rebuilt_second", o_data.rebuilt_second,
                                    want.rebuilt_second);
                if (o_data.check_status !== want.check_status)
                    report_mismatch("check_status", 8'(o_data.check_status),
                                    8'(want.check_status));
            end
        end
    end

    initial begin
        col_cfg_t c;
        t_in      x;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        mismatches  = 0;
        steady      = 1'b0;
        cfg_now     = {RST_MODE, RST_DISKS_IN_USE, RST_FAILED_FIRST, RST_FAILED_SECOND};

        add_row(cfg_now, {64'h0, 8'h00, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});
        add_row({MODE_GEN, 4'd8, 3'd0, 3'd1}, {64'hffff_ffff_ffff_ffff, 8'h00, 8'h00},
                1'b0, '0);
        add_row({MODE_GEN, 4'd1, 3'd0, 3'd1}, {64'h0123_4567_89ab_cdff, 8'h00, 8'h00},
                1'b1, {8'hff, 8'hff, 8'h00, 8'h00, ST_OK});
        add_row({MODE_GEN, 4'd0, 3'd0, 3'd1}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'hff},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});
        add_row({MODE_GEN, 4'd15, 3'd0, 3'd1}, {64'h8040_2010_0804_0201, 8'h00, 8'h00},
                1'b0, '0);
        add_row({MODE_REB_P, 4'd8, 3'd0, 3'd1}, {64'h1122_3344_5566_7788, 8'h5a, 8'h3c},
                1'b0, '0);
        add_row({MODE_REB_P, 4'd8, 3'd7, 3'd1}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'hff},
                1'b0, '0);
        add_row({MODE_REB_P, 4'd4, 3'd6, 3'd1}, {64'hdead_beef_cafe_f00d, 8'h81, 8'h7e},
                1'b0, '0);
        add_row({MODE_REB_Q, 4'd8, 3'd0, 3'd1}, {64'h0f1e_2d3c_4b5a_6978, 8'h00, 8'hff},
                1'b0, '0);
        add_row({MODE_REB_Q, 4'd8, 3'd7, 3'd1}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'h00},
                1'b0, '0);
        add_row({MODE_REB_Q, 4'd3, 3'd5, 3'd1}, {64'h0000_0000_00a5_5a01, 8'h11, 8'h22},
                1'b0, '0);
        add_row({MODE_DUAL, 4'd8, 3'd0, 3'd7}, {64'h0102_0408_1020_4080, 8'hc3, 8'h96},
                1'b0, '0);
        add_row({MODE_DUAL, 4'd8, 3'd7, 3'd0}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'hff},
                1'b0, '0);
        add_row({MODE_DUAL, 4'd8, 3'd3, 3'd3}, {64'h1234_5678_9abc_def0, 8'h5a, 8'hc3},
                1'b1, {8'h5a, 8'hc3, 8'h00, 8'h00, ST_OK});
        add_row({MODE_DUAL, 4'd2, 3'd5, 3'd6}, {64'h7766_5544_3322_1100, 8'h0f, 8'hf0},
                1'b0, '0);
        add_row({MODE_VERIFY, 4'd8, 3'd0, 3'd1}, {64'h0, 8'h00, 8'h00},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});
        add_row({MODE_VERIFY, 4'd0, 3'd0, 3'd1}, {64'h5555_aaaa_5555_aaaa, 8'hff, 8'hff},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_BOTH});
        add_row({MODE_VERIFY, 4'd1, 3'd0, 3'd1}, {64'hffff_ffff_ffff_ff3c, 8'h3c, 8'h00},
                1'b1, {8'h3c, 8'h3c, 8'h00, 8'h00, ST_Q_BAD});
        add_row({MODE_VERIFY, 4'd1, 3'd0, 3'd1}, {64'h0000_0000_0000_003c, 8'h00, 8'h3c},
                1'b1, {8'h3c, 8'h3c, 8'h00, 8'h00, ST_P_BAD});
        add_row({MODE_VERIFY, 4'd8, 3'd0, 3'd1}, {64'hffff_ffff_ffff_ffff, 8'h00, 8'h00},
                1'b0, '0);
        add_row({MODE_RSVD5, 4'd8, 3'd2, 3'd4}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'hff},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});
        add_row({MODE_RSVD6, 4'd1, 3'd0, 3'd0}, {64'h0123_4567_89ab_cdef, 8'h12, 8'h34},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});
        add_row({MODE_RSVD7, 4'd15, 3'd7, 3'd7}, {64'hffff_ffff_ffff_ffff, 8'hff, 8'hff},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h00, ST_OK});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (col_table[r]) begin
            if (col_table[r].cfg != cfg_now) begin
                drain();
                apply_cfg(col_table[r].cfg);
            end
            send_column(col_table[r].col, col_table[r].pinned, col_table[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            c = random_cfg();
            apply_cfg(c);
            steady = (ph >= 12 && ph < 18);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                x = random_column(c);
                send_column(x, 1'b0, '0);
            end
        end
        steady = 1'b0;
        drain();

        if (mismatches == 0 && pending_cols.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
